// ===== rtl/ita_pkg.sv =====
// ita_pkg: shared types, character codes and radix limits for the integer to ascii block
// depends on nothing; imported by ita_ctrl, ita_datapath and integer_to_ascii_any_base
package ita_pkg;

    localparam int CHUNK_BITS = 8;

    localparam logic [4:0] RADIX_MIN   = 5'd2;
    localparam logic [4:0] RADIX_MAX   = 5'd16;
    localparam logic [4:0] RADIX_DEC   = 5'd10;
    localparam logic [4:0] RADIX_RESET = 5'd10;

    localparam logic [6:0] CHAR_ZERO  = 7'h30;
    localparam logic [6:0] CHAR_ALPHA = 7'h41;
    localparam logic [6:0] CHAR_MINUS = 7'h2d;
    localparam logic [6:0] CHAR_NONE  = 7'h00;

    localparam logic [3:0] DIGIT_NINE = 4'd9;
    localparam logic [3:0] DIGIT_TEN  = 4'd10;

    typedef struct packed {
        logic load;
        logic empty;
        logic step;
        logic read;
        logic sign;
        logic emit;
    } ita_cmd_t;

    typedef struct packed {
        logic radix_ok;
        logic last_chunk;
        logic div_done;
        logic minus;
        logic ptr_zero;
    } ita_stat_t;

    function automatic logic [6:0] digit_char(input logic [3:0] d);
        logic [3:0] off;
        off = d - DIGIT_TEN;
        if (d > DIGIT_NINE)
        begin
            return CHAR_ALPHA + {3'b000, off};
        end
        return CHAR_ZERO + {3'b000, d};
    endfunction

endpackage

// ===== rtl/ita_ctrl.sv =====
// ita_ctrl: sequencer for load, digit division, sign and digit output
// depends on ita_pkg; drives ita_datapath through ita_cmd_t, reads ita_stat_t
module ita_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  ita_pkg::ita_stat_t stat,
    output ita_pkg::ita_cmd_t  cmd
);
    import ita_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_PREP = 4'b0100,
        ST_EMIT = 4'b1000
    } ita_state_t;

    ita_state_t state_reg;
    ita_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (stat.radix_ok)
                    begin
                        cmd.load   = 1'b1;
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        cmd.empty = 1'b1;
                    end
                end
            end
            ST_DIV:
            begin
                cmd.step = 1'b1;
                if (stat.last_chunk && stat.div_done)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.read   = 1'b1;
                cmd.sign   = stat.minus;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd.emit = 1'b1;
                if (stat.ptr_zero)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.read = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

    a_load_enters_div: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && stat.radix_ok) |=> (state_reg == ST_DIV))
        else $error("accepted request did not start division");

    a_bad_radix_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !stat.radix_ok) |=> !busy)
        else $error("invalid radix request left the block busy");

    a_final_digit_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && stat.ptr_zero) |=> !busy)
        else $error("block still busy after last character");

endmodule

// ===== rtl/ita_datapath.sv =====
// ita_datapath: radix register, magnitude, byte-wise division unit, digit store, result registers
// depends on ita_pkg; commanded by ita_ctrl
module ita_datapath #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          radix_we,
    input  logic [4:0]                    radix_wdata,
    input  logic signed [VALUE_WIDTH-1:0] value,
    input  ita_pkg::ita_cmd_t             cmd,
    output ita_pkg::ita_stat_t            stat,
    output logic [6:0]                    character,
    output logic                          last,
    output logic                          empty_res,
    output logic                          strobe
);
    import ita_pkg::*;

    localparam int NCH = (VALUE_WIDTH + CHUNK_BITS - 1) / CHUNK_BITS;
    localparam int PW  = NCH * CHUNK_BITS;
    localparam int KW  = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int CW  = $clog2(VALUE_WIDTH + 1);
    localparam int AW  = $clog2(VALUE_WIDTH);

    logic [4:0]             radix_reg;
    logic [PW-1:0]          mag_reg, mag_next;
    logic [3:0]             rem_reg, rem_next;
    logic [KW-1:0]          chunk_reg, chunk_next;
    logic [KW-1:0]          top_reg, top_next;
    logic [CW-1:0]          count_reg, count_next;
    logic                   minus_reg, minus_next;
    logic [3:0]             rd_data_reg;
    logic [6:0]             char_reg, char_next;
    logic                   last_reg, last_next;
    logic                   empty_reg;
    logic                   strobe_reg, strobe_next;

    logic [3:0]             mem [VALUE_WIDTH];

    logic [VALUE_WIDTH-1:0] val_u;
    logic [VALUE_WIDTH-1:0] mag_in;
    logic [CHUNK_BITS-1:0]  chunk_in;
    logic [CHUNK_BITS-1:0]  quo;
    logic [3:0]             rem_div;
    logic [4:0]             trial;
    logic [PW-1:0]          mag_q;
    logic [CW-1:0]          count_inc;
    logic [CW-1:0]          count_dec;
    logic [AW-1:0]          waddr;
    logic [AW-1:0]          raddr;
    logic                   radix_ok;

    assign val_u     = value;
    assign mag_in    = val_u[VALUE_WIDTH-1] ? (~val_u + 1'b1) : val_u;
    assign count_inc = count_reg + 1'b1;
    assign count_dec = count_reg - 1'b1;
    assign waddr     = count_reg[AW-1:0];
    assign raddr     = count_dec[AW-1:0];
    assign chunk_in  = mag_reg[CHUNK_BITS*chunk_reg +: CHUNK_BITS];

    always_comb
    begin
        radix_ok = radix_reg inside {[RADIX_MIN:RADIX_MAX]};
    end

    // restoring division of one byte by the radix
    always_comb
    begin
        rem_div = rem_reg;
        quo     = '0;
        trial   = '0;
        for (int i = CHUNK_BITS - 1; i >= 0; i--)
        begin
            trial = {rem_div, chunk_in[i]};
            if (trial >= radix_reg)
            begin
                quo[i] = 1'b1;
                trial  = trial - radix_reg;
            end
            rem_div = trial[3:0];
        end
        mag_q = mag_reg;
        mag_q[CHUNK_BITS*chunk_reg +: CHUNK_BITS] = quo;
    end

    always_comb
    begin
        mag_next   = mag_reg;
        rem_next   = rem_reg;
        chunk_next = chunk_reg;
        top_next   = top_reg;
        count_next = count_reg;
        minus_next = minus_reg;
        if (cmd.load)
        begin
            mag_next   = PW'(mag_in);
            rem_next   = '0;
            chunk_next = KW'(NCH - 1);
            top_next   = KW'(NCH - 1);
            count_next = '0;
            minus_next = val_u[VALUE_WIDTH-1] && (radix_reg == RADIX_DEC);
        end
        if (cmd.step)
        begin
            mag_next = mag_q;
            rem_next = rem_div;
            // top byte of the quotient gone, skip it on later digits
            if ((chunk_reg == top_reg) && (quo == '0) && (top_reg != '0))
            begin
                top_next = top_reg - 1'b1;
            end
            if (chunk_reg == '0)
            begin
                rem_next   = '0;
                count_next = count_inc;
                chunk_next = top_next;
            end
            else
            begin
                chunk_next = chunk_reg - 1'b1;
            end
        end
        if (cmd.read)
        begin
            count_next = count_dec;
        end
        if (cmd.sign)
        begin
            minus_next = 1'b0;
        end
    end

    always_comb
    begin
        strobe_next = cmd.empty | cmd.sign | cmd.emit;
        char_next   = CHAR_NONE;
        last_next   = 1'b1;
        if (cmd.sign)
        begin
            char_next = CHAR_MINUS;
            last_next = 1'b0;
        end
        else if (cmd.emit)
        begin
            char_next = digit_char(rd_data_reg);
            last_next = (count_reg == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg  <= RADIX_RESET;
            mag_reg    <= '0;
            rem_reg    <= '0;
            chunk_reg  <= '0;
            top_reg    <= '0;
            count_reg  <= '0;
            minus_reg  <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            if (radix_we)
            begin
                radix_reg <= radix_wdata;
            end
            mag_reg    <= mag_next;
            rem_reg    <= rem_next;
            chunk_reg  <= chunk_next;
            top_reg    <= top_next;
            count_reg  <= count_next;
            minus_reg  <= minus_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (strobe_next)
        begin
            char_reg  <= char_next;
            last_reg  <= last_next;
            empty_reg <= cmd.empty;
        end
    end

    // digit store, least significant digit at address 0
    always_ff @(posedge clk)
    begin
        if (cmd.step && (chunk_reg == '0))
        begin
            mem[waddr] <= rem_div;
        end
        if (cmd.read)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    assign stat.radix_ok   = radix_ok;
    assign stat.last_chunk = (chunk_reg == '0);
    assign stat.div_done   = (mag_q == '0) || (count_inc == CW'(VALUE_WIDTH));
    assign stat.minus      = minus_reg;
    assign stat.ptr_zero   = (count_reg == '0);

    assign character = char_reg;
    assign last      = last_reg;
    assign empty_res = empty_reg;
    assign strobe    = strobe_reg;

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && empty_reg) |-> (last_reg && (char_reg == CHAR_NONE)))
        else $error("empty result not marked last or not blank");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(VALUE_WIDTH))
        else $error("digit count beyond store depth");

    a_digit_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && (chunk_reg == '0)) |=> (count_reg == $past(count_inc)))
        else $error("finished digit not counted");

endmodule

// ===== rtl/integer_to_ascii_any_base.sv =====
// integer_to_ascii_any_base: signed integer to ascii digits in a radix of 2 to 16
// throughput: one request per conversion; set by the one byte-per-cycle divide unit and single-port digit store
// invalid radix: one empty result the cycle after start, block not busy
// reset: asynchronous active low, radix back to 10, no result pending; results cannot be stalled
module integer_to_ascii_any_base #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          radix_we,
    input  logic [4:0]                    radix_wdata,
    input  logic signed [VALUE_WIDTH-1:0] value,
    output logic                          strobe,
    output logic [6:0]                    character,
    output logic                          last,
    output logic                          empty_res
);
    import ita_pkg::*;

    ita_cmd_t  cmd;
    ita_stat_t stat;

    ita_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    ita_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .radix_we    (radix_we),
        .radix_wdata (radix_wdata),
        .value       (value),
        .cmd         (cmd),
        .stat        (stat),
        .character   (character),
        .last        (last),
        .empty_res   (empty_res),
        .strobe      (strobe)
    );

endmodule

// ===== tb/sv/integer_to_ascii_any_base_tb.sv =====
`timescale 1ns / 1ps
// integer_to_ascii_any_base_tb: self-checking bench for the integer to ascii converter
// depends on ita_pkg and integer_to_ascii_any_base; directed table then random requests
// over many radix settings, every character checked against typed text or a local digit predictor

module integer_to_ascii_any_base_tb;

    import ita_pkg::*;

    typedef struct packed {
        logic [6:0] character;
        logic       last;
        logic       empty_res;
    } ascii_char_t;

    typedef enum logic [1:0] {
        BY_MODEL,
        TYPED_TEXT,
        TYPED_EMPTY
    } check_kind_t;

    typedef struct {
        logic [4:0]         rdx;
        logic signed [31:0] val;
        check_kind_t        kind;
        string              text;
    } directed_row_t;

    localparam int NUM_PHASES      = 12;
    localparam int ITEMS_PER_PHASE = 40;
    localparam int TAIL_CYCLES     = 150;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               radix_we = 1'b0;
    logic [4:0]         radix_wdata = 5'd0;
    logic signed [31:0] value = 32'sd0;
    logic               strobe;
    logic [6:0]         character;
    logic               last;
    logic               empty_res;

    ascii_char_t   expected_chars [$];
    logic [4:0]    radix_setting = RADIX_RESET;
    int            error_count = 0;
    directed_row_t directed_rows [0:23];

    integer_to_ascii_any_base #(
        .VALUE_WIDTH(32)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .radix_we   (radix_we),
        .radix_wdata(radix_wdata),
        .value      (value),
        .strobe     (strobe),
        .character  (character),
        .last       (last),
        .empty_res  (empty_res)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("%0t ns: %s", $time, what);
        error_count++;
    endtask

    task automatic predict_ascii(input logic signed [31:0] v);
        logic [31:0] magnitude;
        logic [3:0]  digits [$];
        logic [3:0]  d;
        ascii_char_t c;
        if (radix_setting < RADIX_MIN || radix_setting > RADIX_MAX)
        begin
            expected_chars.push_back({CHAR_NONE, 1'b1, 1'b1});
            return;
        end
        magnitude = v[31] ? (32'd0 - v) : v;
        do
        begin
            digits.push_front(4'(magnitude % radix_setting));
            magnitude = magnitude / radix_setting;
        end
        while (magnitude != 32'd0);
        if (v[31] && radix_setting == RADIX_DEC)
        begin
            expected_chars.push_back({CHAR_MINUS, 1'b0, 1'b0});
        end
        foreach (digits[i])
        begin
            d = digits[i];
            c.character = (d > DIGIT_NINE) ? CHAR_ALPHA + 7'(d - DIGIT_TEN) : CHAR_ZERO + 7'(d);
            c.last = (i == digits.size() - 1);
            c.empty_res = 1'b0;
            expected_chars.push_back(c);
        end
    endtask

    task automatic push_typed(input check_kind_t kind, input string text);
        if (kind == TYPED_EMPTY)
        begin
            expected_chars.push_back({CHAR_NONE, 1'b1, 1'b1});
            return;
        end
        for (int i = 0; i < text.len(); i++)
        begin
            expected_chars.push_back({7'(text[i]), i == text.len() - 1, 1'b0});
        end
    endtask

    // called just after a falling edge; returns just after the falling edge after acceptance
    task automatic send_request(input logic signed [31:0] v, input int gap,
                                input check_kind_t kind, input string text);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        value <= v;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        if (kind == BY_MODEL)
        begin
            predict_ascii(v);
        end
        else
        begin
            push_typed(kind, text);
        end
        @(negedge clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (expected_chars.size() != 0 || busy)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic write_radix(input logic [4:0] r);
        radix_we <= 1'b1;
        radix_wdata <= r;
        @(negedge clk);
        radix_we <= 1'b0;
        radix_setting = r;
    endtask

    function automatic logic signed [31:0] random_value();
        logic [31:0] raw;
        int          pick;
        pick = $urandom_range(0, 9);
        raw = $urandom;
        if (pick < 4)
        begin
            return raw;
        end
        if (pick < 7)
        begin
            raw = raw >> $urandom_range(0, 31);
        end
        else if (pick < 9)
        begin
            raw = $urandom_range(0, 40);
        end
        else
        begin
            raw = ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        if (pick < 9 && $urandom_range(0, 1) != 0)
        begin
            raw = 32'd0 - raw;
        end
        return raw;
    endfunction

    function automatic logic [4:0] random_radix();
        if ($urandom_range(0, 4) != 0)
        begin
            return 5'($urandom_range(2, 16));
        end
        if ($urandom_range(0, 1) != 0)
        begin
            return 5'($urandom_range(17, 31));
        end
        return 5'($urandom_range(0, 1));
    endfunction

    always @(posedge clk)
    begin
        ascii_char_t got;
        ascii_char_t want;
        if (strobe)
        begin
            got = {character, last, empty_res};
            if (expected_chars.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result char=%h last=%b empty=%b",
                                          got.character, got.last, got.empty_res));
            end
            else
            begin
                want = expected_chars.pop_front();
                if (got != want)
                begin
                    report_mismatch($sformatf(
                        "char=%h last=%b empty=%b, wanted char=%h last=%b empty=%b",
                        got.character, got.last, got.empty_res,
                        want.character, want.last, want.empty_res));
                end
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("timeout waiting for results");
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        logic [4:0] phase_radix;
        directed_rows = '{
            '{5'd10, 32'sd0,            TYPED_TEXT,  "0"},
            '{5'd10, 32'sh7FFF_FFFF,    TYPED_TEXT,  "2147483647"},
            '{5'd10, 32'sh8000_0000,    TYPED_TEXT,  "-2147483648"},
            '{5'd10, -32'sd1,           TYPED_TEXT,  "-1"},
            '{5'd10, 32'sd9,            BY_MODEL,    ""},
            '{5'd10, -32'sd10,          TYPED_TEXT,  "-10"},
            '{5'd16, -32'sd1,           TYPED_TEXT,  "1"},
            '{5'd16, 32'sh7FFF_FFFF,    TYPED_TEXT,  "7FFFFFFF"},
            '{5'd16, 32'sh8000_0000,    TYPED_TEXT,  "80000000"},
            '{5'd16, 32'sh00AB_CDEF,    TYPED_TEXT,  "ABCDEF"},
            '{5'd16, 32'sd0,            TYPED_TEXT,  "0"},
            '{5'd2,  32'sh8000_0000,    BY_MODEL,    ""},
            '{5'd2,  32'sh7FFF_FFFF,    BY_MODEL,    ""},
            '{5'd2,  32'sd5,            TYPED_TEXT,  "101"},
            '{5'd2,  32'sd0,            TYPED_TEXT,  "0"},
            '{5'd0,  32'sd123,          TYPED_EMPTY, ""},
            '{5'd1,  -32'sd5,           TYPED_EMPTY, ""},
            '{5'd17, 32'sd0,            TYPED_EMPTY, ""},
            '{5'd31, 32'sd7,            TYPED_EMPTY, ""},
            '{5'd3,  32'sh8000_0000,    BY_MODEL,    ""},
            '{5'd7,  32'sd12345,        BY_MODEL,    ""},
            '{5'd8,  -32'sd8,           TYPED_TEXT,  "10"},
            '{5'd15, 32'sd14,           TYPED_TEXT,  "E"},
            '{5'd11, 32'sd10,           TYPED_TEXT,  "A"}
        };

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table, radix only rewritten when a row asks for a new one
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].rdx != radix_setting)
            begin
                wait_drained();
                write_radix(directed_rows[i].rdx);
            end
            send_request(directed_rows[i].val, $urandom_range(0, 11),
                         directed_rows[i].kind, directed_rows[i].text);
        end

        // random requests, one radix per phase; every third phase runs back to back
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                0: phase_radix = RADIX_MAX;
                1: phase_radix = RADIX_MIN;
                2: phase_radix = RADIX_DEC;
                default: phase_radix = random_radix();
            endcase
            wait_drained();
            write_radix(phase_radix);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                send_request(random_value(), (phase % 3 == 0) ? 0 : $urandom_range(0, 11),
                             BY_MODEL, "");
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (error_count == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
